// File: rtl/fbc_pkg.sv
// Shared types and constants for the frustum box culling test block.
// No dependencies; imported by fbc_mac_unit and frustum_box_culling_test_top.
package fbc_pkg;

   localparam int NUM_PLANES = 6;     // stored planes, 1..8
   localparam int FRAC_BITS  = 16;    // fraction bits of the Q format, 8..24

   localparam int IDX_W   = 3;                                  // plane_index field
   localparam int PIDX_W  = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
   localparam int COEF_W  = 32;
   localparam int HALF_W  = 31;
   localparam int CRD_W   = COEF_W + 1;                         // center +/- half
   localparam int PROD_W  = COEF_W + CRD_W;                     // coef * corner
   localparam int ACC_W   = PROD_W + 3;                         // three products + d

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TEST = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   typedef enum logic [1:0] {
      PH_A   = 2'd0,
      PH_B   = 2'd1,
      PH_C   = 2'd2,
      PH_SUM = 2'd3
   } phase_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
      logic signed [COEF_W-1:0] c;
      logic signed [COEF_W-1:0] d;
   } plane_type;

   // Sequencer to MAC unit controls.
   typedef struct packed {
      logic acc_clear;   // load accumulator with d scaled to product format
      logic acc_add;     // add the registered product
   } mac_ctrl_type;

endpackage

// File: rtl/fbc_mac_unit.sv
// Shared multiply-accumulate unit: one 32x33 multiply per cycle, registered,
// then a wide accumulate. Depends on fbc_pkg.
module fbc_mac_unit (
   input  logic                                 clock,
   input  fbc_pkg::mac_ctrl_type                ctrl_i,
   input  logic signed [fbc_pkg::COEF_W-1:0]    coef_i,
   input  logic signed [fbc_pkg::CRD_W-1:0]     coord_i,
   input  logic signed [fbc_pkg::COEF_W-1:0]    d_i,
   output logic                                 sum_neg_o
);
   import fbc_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  d_ext;
   logic signed [ACC_W-1:0]  sum;

   assign prod_in  = PROD_W'(coef_i * coord_i);
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign d_ext    = {{(ACC_W-COEF_W){d_i[COEF_W-1]}}, d_i} <<< FRAC_BITS;
   assign sum      = acc_ff + prod_ext;

   always_comb begin
      priority if (ctrl_i.acc_clear) begin
         acc_in = d_ext;
      end else if (ctrl_i.acc_add) begin
         acc_in = sum;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // zero counts as not negative
   assign sum_neg_o = sum[ACC_W-1];

endmodule

// File: rtl/frustum_box_culling_test_top.sv
// Frustum culling of axis-aligned boxes against stored planes.
// Depends on fbc_pkg and fbc_mac_unit.
//
// Usage:
//  - req channel: one beat per item. req_tuser[0] is the opcode. A load beat
//    writes plane req_tdata[2:0] (ignored if out of range) and returns no rsp
//    beat. A test beat carries a box center and half extents
//    and returns exactly one rsp beat, rsp_tdata[0] = 1 when no plane has the
//    whole box strictly on its negative side.
//  - Each plane is evaluated at the box corner that maximizes a*x+b*y+c*z, which
//    is the all-corners-negative test in one dot product. The shared MAC unit
//    does one coefficient multiply per cycle; each plane runs phases A, B, C and
//    a sum phase, and after the last plane the flush state posts the result to
//    the output register.
//  - req_tready is high only while the sequencer is idle. The result sits in an
//    output register, so further beats are taken while it waits; if the
//    receiver still holds the previous result when a test ends, the block waits
//    in the flush state with req_tready low.
//  - Reset (synchronous, active high) clears all planes to zero (every box then
//    tests inside), the sequencer, and the rsp valid.
module frustum_box_culling_test_top (
   input  logic          clock,
   input  logic          reset,
   // req_tdata, low bit up: plane_index[2:0], coef_a[34:3], coef_b[66:35],
   // coef_c[98:67], coef_d[130:99], center_x[162:131], center_y[194:163],
   // center_z[226:195], half_x[257:227], half_y[288:258], half_z[319:289]
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [319:0]  req_tdata,
   input  logic [0:0]    req_tuser,    // opcode[0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata     // inside_res[0], zero fill above
);
   import fbc_pkg::*;

   // unpacked request fields
   logic [IDX_W-1:0]         plane_index;
   logic signed [COEF_W-1:0] coef_a, coef_b, coef_c, coef_d;
   logic signed [COEF_W-1:0] center_x, center_y, center_z;
   logic [HALF_W-1:0]        half_x, half_y, half_z;
   opcode_type               opcode;

   assign plane_index = req_tdata[2:0];
   assign coef_a      = req_tdata[34:3];
   assign coef_b      = req_tdata[66:35];
   assign coef_c      = req_tdata[98:67];
   assign coef_d      = req_tdata[130:99];
   assign center_x    = req_tdata[162:131];
   assign center_y    = req_tdata[194:163];
   assign center_z    = req_tdata[226:195];
   assign half_x      = req_tdata[257:227];
   assign half_y      = req_tdata[288:258];
   assign half_z      = req_tdata[319:289];
   assign opcode      = opcode_type'(req_tuser[0]);

   // state
   state_type                state_ff, state_in;
   phase_type                phase_ff, phase_in;
   logic [PIDX_W-1:0]        plane_ff, plane_in;
   logic                     outside_ff, outside_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_inside_ff, rsp_inside_in;
   plane_type                store_ff [NUM_PLANES];

   // captured box
   logic signed [COEF_W-1:0] cx_ff, cy_ff, cz_ff;
   logic [HALF_W-1:0]        hx_ff, hy_ff, hz_ff;

   logic                     req_beat;
   logic                     load_hit;
   logic                     out_free;
   logic                     last_plane;
   plane_type                cur_plane;
   logic signed [COEF_W-1:0] coef_sel;
   logic signed [COEF_W-1:0] ctr_sel;
   logic [HALF_W-1:0]        half_sel;
   logic signed [CRD_W-1:0]  coord_sel;
   mac_ctrl_type             mac_ctrl;
   logic                     sum_neg;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign load_hit   = req_beat && (opcode == OP_LOAD)
                       && ({1'b0, plane_index} < (IDX_W+1)'(NUM_PLANES));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_plane = (plane_ff == PIDX_W'(NUM_PLANES - 1));
   assign cur_plane  = store_ff[plane_ff];

   // operand select for the current phase
   always_comb begin
      unique case (phase_ff)
         PH_A: begin
            coef_sel = cur_plane.a;  ctr_sel = cx_ff;  half_sel = hx_ff;
         end
         PH_B: begin
            coef_sel = cur_plane.b;  ctr_sel = cy_ff;  half_sel = hy_ff;
         end
         PH_C: begin
            coef_sel = cur_plane.c;  ctr_sel = cz_ff;  half_sel = hz_ff;
         end
         default: begin
            coef_sel = cur_plane.a;  ctr_sel = cx_ff;  half_sel = hx_ff;
         end
      endcase
   end

   // corner that maximizes coef*coord: low edge for a negative coefficient
   always_comb begin
      if (coef_sel[COEF_W-1]) begin
         coord_sel = {ctr_sel[COEF_W-1], ctr_sel} - CRD_W'({2'b00, half_sel});
      end else begin
         coord_sel = {ctr_sel[COEF_W-1], ctr_sel} + CRD_W'({2'b00, half_sel});
      end
   end

   assign mac_ctrl.acc_clear = (state_ff == ST_RUN) && (phase_ff == PH_A);
   assign mac_ctrl.acc_add   = (state_ff == ST_RUN)
                               && ((phase_ff == PH_B) || (phase_ff == PH_C));

   fbc_mac_unit u_mac (
      .clock     (clock),
      .ctrl_i    (mac_ctrl),
      .coef_i    (coef_sel),
      .coord_i   (coord_sel),
      .d_i       (cur_plane.d),
      .sum_neg_o (sum_neg)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      plane_in      = plane_ff;
      outside_in    = outside_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && (opcode == OP_TEST)) begin
               state_in   = ST_RUN;
               phase_in   = PH_A;
               plane_in   = '0;
               outside_in = 1'b0;
            end
         end
         ST_RUN: begin
            unique case (phase_ff)
               PH_A:    phase_in = PH_B;
               PH_B:    phase_in = PH_C;
               PH_C:    phase_in = PH_SUM;
               default: begin
                  phase_in = PH_A;
                  if (sum_neg) begin
                     outside_in = 1'b1;   // whole box behind this plane
                  end
                  if (last_plane) begin
                     state_in = ST_FLUSH;
                  end else begin
                     plane_in = plane_ff + PIDX_W'(1);
                  end
               end
            endcase
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = !outside_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_A;
         plane_ff     <= '0;
         outside_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         plane_ff     <= plane_in;
         outside_ff   <= outside_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // plane store, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            store_ff[i] <= '0;
         end
      end else if (load_hit) begin
         store_ff[plane_index[PIDX_W-1:0]] <= '{a: coef_a, b: coef_b,
                                                 c: coef_c, d: coef_d};
      end
   end

   // box capture and result payload
   always_ff @(posedge clock) begin
      if (req_beat && (opcode == OP_TEST)) begin
         cx_ff <= center_x;
         cy_ff <= center_y;
         cz_ff <= center_z;
         hx_ff <= half_x;
         hy_ff <= half_y;
         hz_ff <= half_z;
      end
      rsp_inside_ff <= rsp_inside_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0000000, rsp_inside_ff};

endmodule

// File: bench/frustum_box_culling_test_top_tb.sv
// Self-checking bench for frustum_box_culling_test_top: plane loads and box tests
// over the req/rsp streams, with a scoreboard that holds its own copy of the planes.
// Depends on fbc_pkg and the RTL of the block; nothing else.
`timescale 1ns / 100ps

import fbc_pkg::*;

// Holds a mirror of the plane store and the queue of inside verdicts still owed.
class box_verdict_board;
   localparam int WIDE_W = 80;   // wide enough for coef * (center +/- half) sums

   plane_type planes [NUM_PLANES];
   bit        expected_inside [$];
   int        errors;
   int        checked;

   function new();
      for (int i = 0; i < NUM_PLANES; i++) planes[i] = '0;
      errors  = 0;
      checked = 0;
   endfunction

   // Exact sign test of every corner against every plane.
   function bit box_inside(logic [319:0] data);
      logic signed [WIDE_W-1:0] cx, cy, cz, hx, hy, hz;
      logic signed [WIDE_W-1:0] x, y, z, a, b, c, d, dot;
      bit all_neg;
      cx = $signed(data[162:131]);
      cy = $signed(data[194:163]);
      cz = $signed(data[226:195]);
      hx = data[257:227];
      hy = data[288:258];
      hz = data[319:289];
      for (int p = 0; p < NUM_PLANES; p++) begin
         a = $signed(planes[p].a);
         b = $signed(planes[p].b);
         c = $signed(planes[p].c);
         d = $signed(planes[p].d);
         all_neg = 1'b1;
         for (int k = 0; k < 8; k++) begin
            x = k[0] ? cx + hx : cx - hx;
            y = k[1] ? cy + hy : cy - hy;
            z = k[2] ? cz + hz : cz - hz;
            dot = a * x + b * y + c * z + (d <<< FRAC_BITS);
            if (dot >= 0) all_neg = 1'b0;   // zero counts as not negative
         end
         if (all_neg) return 1'b0;
      end
      return 1'b1;
   endfunction

   function void note_request(logic op, logic [319:0] data);
      logic [IDX_W-1:0] idx;
      idx = data[2:0];
      if (op == OP_LOAD) begin
         if (idx < NUM_PLANES)
            planes[idx] = '{a: data[34:3], b: data[66:35], c: data[98:67], d: data[130:99]};
      end else begin
         expected_inside.push_back(box_inside(data));
      end
   endfunction

   function void check_verdict(logic [7:0] tdata);
      bit exp_inside;
      checked++;
      if (expected_inside.size() == 0) begin
         errors++;
         $display("%0t: rsp beat with nothing expected, actual inside_res=%b",
                  $time, tdata[0]);
      end else begin
         exp_inside = expected_inside.pop_front();
         if (tdata[0] !== exp_inside) begin
            errors++;
            $display("%0t: inside_res mismatch, expected %b actual %b",
                     $time, exp_inside, tdata[0]);
         end
      end
   endfunction

   function int pending();
      return expected_inside.size();
   endfunction
endclass

module frustum_box_culling_test_top_tb;

   localparam int          CYCLE_LIMIT  = 500000;
   localparam int          RANDOM_BEATS = 1650;
   localparam int          DRAIN_CYCLES = 40;
   localparam int          HOLD_CYCLES  = 400;
   localparam logic [31:0] Q_ONE  = 32'h0001_0000;
   localparam logic [31:0] Q_MAX  = 32'h7fff_ffff;
   localparam logic [31:0] Q_MIN  = 32'h8000_0000;
   localparam logic [30:0] H_MAX  = 31'h7fff_ffff;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [319:0] req_tdata  = '0;
   logic [0:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;

   box_verdict_board board = new();

   int  cycles     = 0;
   int  sent       = 0;     // beats that load a real plane or run a test
   bit  calm       = 1'b0;  // no idling on either side while set
   int  hold_left  = 0;
   bit  hold_done  = 1'b0;

   frustum_box_culling_test_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("frustum_box_culling_test_top_tb: FAIL");
         $finish;
      end
   end

   // Monitor: both channels sampled at the rising edge, inputs are stable by then.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_request(req_tuser[0], req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_verdict(rsp_tdata);
      end
   end

   // Receiver: random backpressure, plus one long hold-off once some results are in,
   // so the output register fills and the block parks in flush with req_tready low.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else if (!hold_done && board.checked >= 150) begin
         hold_done  = 1'b1;
         hold_left  = HOLD_CYCLES - 1;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = calm || ($urandom_range(99) >= 21);
      end
   end

   function automatic logic [319:0] pack_req(
      logic [2:0]  idx,
      logic [31:0] a, b, c, d,
      logic [31:0] cx, cy, cz,
      logic [30:0] hx, hy, hz);
      return {hz, hy, hx, cz, cy, cx, d, c, b, a, idx};
   endfunction

   // Coefficient / coordinate values: extremes, small and medium magnitudes, full range.
   function automatic logic [31:0] rand_word();
      logic [31:0] v;
      case ($urandom_range(9))
         0:       v = '0;
         1:       v = Q_MAX;
         2:       v = Q_MIN;
         3:       v = $urandom_range(0, 1 << 20);
         4, 5:    v = $urandom_range(0, 1 << 24);
         default: v = $urandom;
      endcase
      if ($urandom_range(1) && $urandom_range(9) inside {[3:5]}) v = -v;
      return v;
   endfunction

   function automatic logic [30:0] rand_half();
      logic [31:0] r;
      case ($urandom_range(5))
         0:       r = 0;
         1:       r = {1'b0, H_MAX};
         2:       r = $urandom_range(0, 1 << 18);
         3:       r = $urandom_range(0, 1 << 24);
         default: r = $urandom;
      endcase
      return r[30:0];
   endfunction

   // One req beat: random idle cycles first, then hold valid until accepted.
   task automatic send_beat(opcode_type op, logic [319:0] data);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 21) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_TEST || data[2:0] < NUM_PLANES) sent++;
      calm = (sent >= 500 && sent < 700);
   endtask

   // Box fields of a load are don't-care, so they get noise.
   task automatic load_plane(logic [2:0] idx, logic [31:0] a, b, c, d);
      send_beat(OP_LOAD, pack_req(idx, a, b, c, d, $urandom, $urandom, $urandom,
                                  31'($urandom), 31'($urandom), 31'($urandom)));
   endtask

   // Index and coefficients of a test are don't-care as well.
   task automatic test_box(logic [31:0] cx, cy, cz, logic [30:0] hx, hy, hz);
      send_beat(OP_TEST, pack_req(3'($urandom), $urandom, $urandom, $urandom, $urandom,
                                  cx, cy, cz, hx, hy, hz));
   endtask

   task automatic wait_drained();
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int          n;
      logic [2:0]  idx;
      logic [30:0] h;
      bit          paused;
      paused = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed ---
      // planes are all zero after reset: everything is inside
      test_box(32'h0, 32'h0, 32'h0, 31'h0, 31'h0, 31'h0);
      test_box(Q_MIN, Q_MAX, Q_MIN, H_MAX, H_MAX, H_MAX);
      // plane x >= 0: one lsb below, exactly on, box touching, box fully behind
      load_plane(3'd0, Q_ONE, 32'h0, 32'h0, 32'h0);
      test_box(32'hffff_ffff, 32'h0, 32'h0, 31'h0, 31'h0, 31'h0);
      test_box(32'h0, 32'h0, 32'h0, 31'h0, 31'h0, 31'h0);
      test_box(-Q_ONE, 32'h0, 32'h0, Q_ONE[30:0], 31'h0, 31'h0);
      test_box(32'hffff_fffe, 32'h0, 32'h0, 31'h1, 31'h1, 31'h1);   // cube
      // out-of-range plane index is dropped
      load_plane(3'd6, 32'h0, 32'h0, 32'h0, 32'hffff_ffff);
      load_plane(3'd7, 32'h0, 32'h0, 32'h0, 32'hffff_ffff);
      test_box(32'h5, 32'h0, 32'h0, 31'h0, 31'h0, 31'h0);
      // constant-negative plane culls everything
      load_plane(3'd5, 32'h0, 32'h0, 32'h0, 32'hffff_ffff);
      test_box(Q_MAX, Q_MAX, Q_MAX, H_MAX, H_MAX, H_MAX);
      load_plane(3'd5, 32'h0, 32'h0, 32'h0, 32'h0);
      load_plane(3'd0, 32'h0, 32'h0, 32'h0, 32'h0);
      // extreme coefficients against extreme corners
      load_plane(3'd1, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      test_box(Q_MAX, Q_MAX, Q_MAX, H_MAX, H_MAX, H_MAX);
      test_box(Q_MIN, Q_MIN, Q_MIN, 31'h0, 31'h0, 31'h0);
      load_plane(3'd2, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      test_box(Q_MIN, Q_MIN, Q_MIN, H_MAX, H_MAX, H_MAX);
      test_box(Q_MAX, Q_MIN, 32'h0, H_MAX, 31'h0, Q_ONE[30:0]);
      load_plane(3'd3, Q_MIN, Q_MAX, Q_MIN, 32'h0);
      test_box(Q_ONE, Q_ONE, Q_ONE, Q_ONE[30:0], Q_ONE[30:0], Q_ONE[30:0]);
      load_plane(3'd4, 32'h0, -Q_ONE, 32'h0, Q_ONE);                // y <= 1
      test_box(32'h0, 3 * Q_ONE, 32'h0, Q_ONE[30:0], Q_ONE[30:0], Q_ONE[30:0]);

      // --- random ---
      sent = 0;
      while (sent < RANDOM_BEATS) begin
         if ($urandom_range(99) < 75) begin
            // reload a few planes (some cleared so boxes are not always culled), then test
            n = $urandom_range(1, 6);
            repeat (n) begin
               idx = ($urandom_range(19) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
               if ($urandom_range(99) < 30)
                  load_plane(idx, 32'h0, 32'h0, 32'h0, 32'h0);
               else
                  load_plane(idx, rand_word(), rand_word(), rand_word(), rand_word());
            end
            n = $urandom_range(2, 8);
            repeat (n) begin
               if ($urandom_range(4) == 0) begin
                  h = rand_half();
                  test_box(rand_word(), rand_word(), rand_word(), h, h, h);
               end else begin
                  test_box(rand_word(), rand_word(), rand_word(),
                           rand_half(), rand_half(), rand_half());
               end
            end
         end else begin
            // raw noise beats, any opcode and index
            n = $urandom_range(1, 4);
            repeat (n)
               send_beat(opcode_type'($urandom_range(1)),
                         {$urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom});
         end
         if (!paused && sent >= 1000) begin
            // sender goes quiet until every owed result is back
            paused = 1'b1;
            @(negedge clock);
            req_tvalid = 1'b0;
            wait_drained();
         end
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.errors == 0 && board.pending() == 0) begin
         $display("frustum_box_culling_test_top_tb: PASS");
      end else begin
         $display("frustum_box_culling_test_top_tb: FAIL");
      end
      $finish;
   end

endmodule
